// ===== sv/ksv_pkg.sv =====
`default_nettype none

package ksv_pkg;

    localparam int unsigned KeyCount   = 12;
    localparam int unsigned PhaseWidth = 32;

    localparam logic [3:0] NoteNone  = 4'd12;
    localparam logic [3:0] VolumeMax = 4'd8;
    localparam logic [7:0] MidScale  = 8'd128;

    // Item kinds carried on the slave tuser bit
    localparam logic ModeScan = 1'b0;
    localparam logic ModeTick = 1'b1;

    // Knob contact pair codes, high bit first
    localparam logic [1:0] KnobLow   = 2'b00;
    localparam logic [1:0] KnobHalf  = 2'b10;
    localparam logic [1:0] KnobHigh  = 2'b11;

    typedef struct packed {
        logic                    mode;
        logic [KeyCount-1:0]     key_rows;
        logic [1:0]              knob_bits;
    } t_ksv_item;

    typedef struct packed {
        logic [7:0] sample;
        logic [3:0] note;
        logic [3:0] volume;
    } t_ksv_result;

    // Phase increment per note; no key and unused codes hold the phase
    function automatic logic [PhaseWidth-1:0] note_step(input logic [3:0] note);
        logic [PhaseWidth-1:0] step;
        unique case (note)
            4'd0:    step = 32'd51076057;
            4'd1:    step = 32'd54113197;
            4'd2:    step = 32'd57330935;
            4'd3:    step = 32'd60740010;
            4'd4:    step = 32'd64351799;
            4'd5:    step = 32'd68178356;
            4'd6:    step = 32'd72232452;
            4'd7:    step = 32'd76527617;
            4'd8:    step = 32'd81078186;
            4'd9:    step = 32'd85899346;
            4'd10:   step = 32'd91007189;
            4'd11:   step = 32'd96418756;
            default: step = '0;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ksv_voice.sv =====
`default_nettype none

module ksv_voice (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire ksv_pkg::t_ksv_item   i_item,
    output ksv_pkg::t_ksv_result      o_result
);
    import ksv_pkg::*;

    logic [PhaseWidth-1:0] r_phase, n_phase;
    logic [3:0]            r_note, n_note;
    logic [3:0]            r_volume, n_volume;
    logic                  r_knob_phase, n_knob_phase;

    logic [3:0]            key_note;
    logic                  vol_up, vol_down;
    logic [PhaseWidth-1:0] tick_phase;
    logic [3:0]            vol_sat;
    logic [3:0]            shift_amt;
    logic signed [7:0]     centered;
    logic signed [7:0]     scaled;
    logic [7:0]            tick_sample;

    // Pick the highest-indexed pressed key; its note is the index with the column reversed
    always_comb begin
        key_note = NoteNone;
        for (int i = 0; i < KeyCount; i++) begin
            if (!i_item.key_rows[i]) begin
                key_note = 4'(i) ^ 4'd3;
            end
        end
    end

    // Two-state knob decode
    always_comb begin
        vol_up       = 1'b0;
        vol_down     = 1'b0;
        n_knob_phase = r_knob_phase;
        if (!r_knob_phase) begin
            if (i_item.knob_bits == KnobHigh) begin
                vol_down     = 1'b1;
                n_knob_phase = 1'b1;
            end else if (i_item.knob_bits == KnobHalf) begin
                vol_up       = 1'b1;
                n_knob_phase = 1'b1;
            end
        end else begin
            if (i_item.knob_bits == KnobHalf) begin
                vol_down     = 1'b1;
                n_knob_phase = 1'b0;
            end else if (i_item.knob_bits == KnobLow) begin
                vol_up       = 1'b1;
                n_knob_phase = 1'b0;
            end
        end
    end

    // Advance the accumulator and scale the top byte by the volume
    always_comb begin
        tick_phase  = r_phase + note_step(r_note);
        vol_sat     = (r_volume > VolumeMax) ? VolumeMax : r_volume;
        shift_amt   = VolumeMax - vol_sat;
        centered    = signed'({~tick_phase[PhaseWidth-1], tick_phase[PhaseWidth-2 -: 7]});
        scaled      = centered >>> shift_amt;
        tick_sample = {~scaled[7], scaled[6:0]};
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_phase  = r_phase;
        n_note   = r_note;
        n_volume = r_volume;
        o_result.sample = MidScale;
        if (i_item.mode == ModeTick) begin
            n_phase         = tick_phase;
            o_result.sample = tick_sample;
        end else begin
            n_note = key_note;
            if (vol_up && r_volume < VolumeMax) begin
                n_volume = r_volume + 4'd1;
            end else if (vol_down && r_volume != 4'd0) begin
                n_volume = r_volume - 4'd1;
            end
        end
        o_result.note   = n_note;
        o_result.volume = n_volume;
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_note       <= NoteNone;
            r_volume     <= '0;
            r_knob_phase <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_note   <= n_note;
            r_volume <= n_volume;
            if (i_item.mode == ModeScan) begin
                r_knob_phase <= n_knob_phase;
            end
        end
    end

    a_volume_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_volume <= VolumeMax)
        else $error("volume count left its range");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_note <= NoteNone)
        else $error("note index left its range");

    a_tick_keeps_controls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.mode == ModeTick) |=> ($stable(r_note) && $stable(r_volume)))
        else $error("sample tick changed note or volume");

endmodule

`default_nettype wire

// ===== sv/keyboard_sawtooth_synth_voice_unit.sv =====
`default_nettype none

// Channel  | Dir | tdata (low bit first)                 | tuser
// s_axis   | in  | key_rows[11:0], knob_bits[1:0], 2'b0  | mode (0 scan, 1 sample tick)
// m_axis   | out | sample[7:0], note[3:0], volume[3:0]   | -
//
// One item per cycle sustained while the output is not stalled; each item
// passes from the input register into the result register.
// The voice state (phase, note, volume, knob phase) is updated in the cycle
// the item leaves the input register. Reset sets note to 12, the rest to 0.
// A stalled output holds its result; the input register still takes an item
// while the result waits, then input ready drops until the output drains.

module keyboard_sawtooth_synth_voice_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // key_rows[11:0], knob_bits[13:12], zero
    input  wire logic        s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // sample[7:0], note[11:8], volume[15:12]
);
    import ksv_pkg::*;

    logic        r_in_valid;
    t_ksv_item   r_in;
    logic        r_out_valid;
    t_ksv_result r_out;

    logic        out_load;
    logic        in_take;
    t_ksv_result result;

    // Result register loads when empty or being drained this cycle
    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ksv_voice u_voice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (out_load),
        .i_item   (r_in),
        .o_result (result)
    );

    // Hold the input register until its item transfers onward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.mode      <= s_axis_tuser;
            r_in.key_rows  <= s_axis_tdata[11:0];
            r_in.knob_bits <= s_axis_tdata[13:12];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.volume, r_out.note, r_out.sample};

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result register empty after load");

    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid)
        else $error("stalled result dropped");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input ready while both registers are full and stalled");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_load) |=> r_in_valid)
        else $error("pending input item lost");

endmodule

`default_nettype wire

// ===== tb/sv/tb_keyboard_sawtooth_synth_voice_unit.sv =====
`default_nettype none

module tb_keyboard_sawtooth_synth_voice_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ksv_pkg::*;

    // Knob pair code with no package name: leaves the decode where it is
    localparam logic [1:0] KnobOpen = 2'b01;

    // Phase increment per note index; index 12 (no key) holds the phase
    localparam logic [31:0] NoteStep [13] = '{
        32'd51076057, 32'd54113197, 32'd57330935, 32'd60740010,
        32'd64351799, 32'd68178356, 32'd72232452, 32'd76527617,
        32'd81078186, 32'd85899346, 32'd91007189, 32'd96418756,
        32'd0
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // key_rows[11:0], knob_bits[13:12], zero
    logic        s_axis_tuser  = 1'b0; // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // sample[7:0], note[11:8], volume[15:12]

    // Voice state tracked alongside the block
    logic [31:0] voice_phase      = '0;
    logic [3:0]  voice_note       = NoteNone;
    logic [3:0]  voice_volume     = '0;
    logic        voice_knob_phase = 1'b0;

    t_ksv_result expected_voice_q[$];
    int          mismatch_count     = 0;
    int          hold_output_cycles = 0;
    bit          tx_idle_en         = 1'b0;
    bit          rx_idle_en         = 1'b0;

    keyboard_sawtooth_synth_voice_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Pick an idle length: mostly none, some short, a few long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(3, 1);
        if (pick < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Advance the voice state by one accepted item and queue its result
    task automatic predict_voice(input logic mode, input logic [11:0] keys,
                                 input logic [1:0] knob);
        t_ksv_result res;
        int          cnt;
        int          level;
        int          shift_amt;
        logic [3:0]  vol;
        res.sample = MidScale;
        if (mode == ModeScan) begin
            cnt = voice_volume;
            if (!voice_knob_phase) begin
                if (knob == KnobHigh) begin
                    cnt--;
                    voice_knob_phase = 1'b1;
                end else if (knob == KnobHalf) begin
                    cnt++;
                    voice_knob_phase = 1'b1;
                end
            end else begin
                if (knob == KnobHalf) begin
                    cnt--;
                    voice_knob_phase = 1'b0;
                end else if (knob == KnobLow) begin
                    cnt++;
                    voice_knob_phase = 1'b0;
                end
            end
            // Clamp as signed values so a step below zero stays at zero
            if (cnt > int'(VolumeMax)) cnt = int'(VolumeMax);
            if (cnt < 0) cnt = 0;
            voice_volume = 4'(cnt);
            // Last pressed key in scan order wins
            voice_note = NoteNone;
            for (int r = 0; r < 3; r++) begin
                for (int b = 0; b < 4; b++) begin
                    if (!keys[4*r+b]) voice_note = 4'(4*r + 3 - b);
                end
            end
        end else begin
            voice_phase = voice_phase + ((voice_note <= NoteNone) ? NoteStep[voice_note] : '0);
            vol       = (voice_volume > VolumeMax) ? VolumeMax : voice_volume;
            shift_amt = 8 - int'(vol);
            level     = int'(voice_phase[31:24]) - 128;
            level     = level >>> shift_amt;
            res.sample = 8'(level + 128);
        end
        res.note   = voice_note;
        res.volume = voice_volume;
        expected_voice_q.push_back(res);
    endtask

    // Offer one item, hold it until the transfer, then predict its result
    task automatic send_item(input logic mode, input logic [11:0] keys,
                             input logic [1:0] knob);
        int gap;
        gap = tx_idle_en ? idle_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, knob, keys};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_voice(mode, keys, knob);
    endtask

    // Stop offering and wait until every queued result has come out
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_voice_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [11:0] one_key(input int k);
        return ~(12'd1 << k);
    endfunction

    // Random scan or tick, keys biased toward single presses
    task automatic send_random_item();
        logic [11:0] keys;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 40) keys = one_key($urandom_range(11));
        else if (pick < 55) keys = 12'hFFF;
        else keys = 12'($urandom);
        send_item(($urandom_range(99) < 35) ? ModeScan : ModeTick, keys,
                  2'($urandom_range(3)));
    endtask

    // Ticks straight out of reset: silent note, volume zero
    task automatic test_reset_values();
        send_item(ModeTick, 12'hFFF, KnobLow);
        send_item(ModeTick, 12'h000, KnobHigh);
        // Lower from zero: count saturates at the bottom
        send_item(ModeScan, 12'hFFF, KnobHigh);
        send_item(ModeScan, 12'hFFF, KnobHalf);
        wait_drain();
    endtask

    // Every single key with the knob turning up past full volume
    task automatic test_keys_and_knob();
        for (int k = 0; k < 12; k++) begin
            send_item(ModeScan, one_key(k), (k % 2 == 0) ? KnobHalf : KnobLow);
            if (k % 4 == 3) send_item(ModeTick, 12'($urandom), 2'($urandom_range(3)));
        end
        // All keys down, then one step and knob pairs that hold the decode in phase 1
        send_item(ModeScan, 12'h000, KnobHalf);
        send_item(ModeScan, 12'h000, KnobOpen);
        send_item(ModeScan, 12'h000, KnobHigh);
        send_item(ModeTick, 12'hFFF, KnobLow);
        send_item(ModeScan, 12'hFFF, KnobOpen);
        send_item(ModeTick, 12'h000, KnobHigh);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input bit idle);
        tx_idle_en = idle;
        rx_idle_en = idle;
        for (int n = 0; n < count; n++) send_random_item();
        wait_drain();
    endtask

    // Long output stall while input keeps offering: block fills and stalls
    task automatic test_output_stall();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_output_cycles = 300;
        for (int n = 0; n < 60; n++) send_random_item();
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_keys_and_knob();
        test_random_traffic(600, 1'b0);
        test_random_traffic(1300, 1'b1);
        test_output_stall();
        test_random_traffic(100, 1'b1);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_voice_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Receiver: long hold-off on request, otherwise random stalls when enabled
    initial begin
        int gap_left;
        gap_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_output_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_output_cycles--;
            end else if (gap_left > 0) begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_idle_en) gap_left = idle_length();
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_ksv_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_voice_q.size() == 0) begin
                $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_res = expected_voice_q.pop_front();
                if (m_axis_tdata[7:0] !== exp_res.sample) begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             exp_res.sample, m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[11:8] !== exp_res.note) begin
                    $display("%0t: note expected %0d actual %0d", $time,
                             exp_res.note, m_axis_tdata[11:8]);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:12] !== exp_res.volume) begin
                    $display("%0t: volume expected %0d actual %0d", $time,
                             exp_res.volume, m_axis_tdata[15:12]);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #(64'd20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
